>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the video memory mirroring unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low reset).
`define PVMM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("pvmm assertion failed");

// Clocked check that also holds during reset.
`define PVMM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pvmm assertion failed");

`endif

>>> rtl/core/pvmm_pkg.sv
// ----------------------------------------------------------------------------
// pvmm_pkg
// Shared constants, codes and control types of the video memory unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvmm_pkg;

    localparam int NT_DEPTH_DEF = 4096;
    localparam int PAL_DEPTH    = 32;
    localparam int PAL_AW       = 5;
    localparam int NT_FIELD_W   = 12;

    localparam logic [15:0] PAL_BASE = 16'h3F00;
    localparam logic [15:0] NT_BASE  = 16'h2000;

    localparam logic [NT_FIELD_W-1:0] NT_MIRROR_H = 12'h400;
    localparam logic [NT_FIELD_W-1:0] NT_MIRROR_V = 12'h800;
    localparam logic [PAL_AW-1:0]     PAL_MIRROR  = 5'h10;

    localparam logic [1:0] MIRROR_NONE = 2'd0;
    localparam logic [1:0] MIRROR_HORZ = 2'd1;
    localparam logic [1:0] MIRROR_VERT = 2'd2;

    localparam logic [1:0] CART_NONE    = 2'd0;
    localparam logic [1:0] CART_RD_VROM = 2'd1;
    localparam logic [1:0] CART_RD_RAM  = 2'd2;
    localparam logic [1:0] CART_WR_RAM  = 2'd3;

    localparam logic FUNC_WRITE = 1'b1;

    localparam logic CFG_MIRROR_MODE  = 1'b0;
    localparam logic CFG_CART_HAS_RAM = 1'b1;

    typedef struct packed {
        logic load_item;
        logic wr_mirror;
        logic cap_read;
        logic clear_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_nt;
        logic is_write;
        logic need_mirror;
        logic clear_last;
        logic out_valid;
    } dp_status_t;

endpackage

>>> rtl/core/ppu_video_memory_mirroring_unit.sv
// ----------------------------------------------------------------------------
// ppu_video_memory_mirroring_unit
// Video memory of a picture unit: palette and nametable stores with
// mirroring, and cartridge request generation for pattern space.
// ----------------------------------------------------------------------------
// After reset the unit clears the nametable RAM, one entry per cycle, until
// all NAMETABLE_DEPTH entries are zero; s_ready stays low until that pass ends,
// while configuration writes are taken at any time. Then each transaction gives
// one result. Palette and cartridge results load when the transaction is taken.
// A nametable read passes through the registered RAM read and a read state; a
// mirrored nametable write passes through a mirror state, as the single RAM port
// stores the copy after the first write. A new transaction is taken in the idle
// state when the result register is empty or is being emptied in the same cycle.
`timescale 1ns / 1ps

module ppu_video_memory_mirroring_unit
    import pvmm_pkg::*;
#(
    parameter int NAMETABLE_DEPTH = NT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_addr,
    input  logic [7:0]  s_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [1:0]  m_cart_op,
    output logic [12:0] m_cart_addr,
    output logic [7:0]  m_cart_data
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    pvmm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pvmm_dp #(
        .NAMETABLE_DEPTH (NAMETABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_func      (s_func),
        .s_addr      (s_addr),
        .s_wdata     (s_wdata),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_read_data (m_read_data),
        .m_cart_op   (m_cart_op),
        .m_cart_addr (m_cart_addr),
        .m_cart_data (m_cart_data),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

>>> rtl/core/pvmm_ram.sv
// ----------------------------------------------------------------------------
// pvmm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/pvmm_dp.sv
// ----------------------------------------------------------------------------
// pvmm_dp
// Datapath: address decode, palette registers, nametable RAM port, clear
// counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvmm_dp
    import pvmm_pkg::*;
#(
    parameter int NAMETABLE_DEPTH = NT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_func,
    input  logic [15:0] s_addr,
    input  logic [7:0]  s_wdata,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [7:0]  m_read_data,
    output logic [1:0]  m_cart_op,
    output logic [12:0] m_cart_addr,
    output logic [7:0]  m_cart_data,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  st
);

    localparam int NT_AW = $clog2(NAMETABLE_DEPTH);
    localparam logic [NT_FIELD_W:0] NT_DEPTH_W = (NT_FIELD_W+1)'(NAMETABLE_DEPTH);
    localparam logic [NT_AW-1:0]    NT_LAST    = NT_AW'(NAMETABLE_DEPTH - 1);

    logic [1:0]       mirror_mode_reg, mirror_mode_next;
    logic             cart_ram_reg, cart_ram_next;
    logic [7:0]       pal_reg [PAL_DEPTH];
    logic [7:0]       pal_next [PAL_DEPTH];
    logic [NT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NT_AW-1:0] mir_idx_reg, mir_idx_next;
    logic [7:0]       mir_data_reg, mir_data_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       rd_reg, rd_next;
    logic [1:0]       op_reg, op_next;
    logic [12:0]      caddr_reg, caddr_next;
    logic [7:0]       cdata_reg, cdata_next;

    logic                  is_pal, is_nt, is_write;
    logic [PAL_AW-1:0]     pal_idx;
    logic [NT_FIELD_W-1:0] nt_raw, nt_mraw;
    logic [NT_FIELD_W:0]   nt_full, nt_mfull;
    logic [NT_AW-1:0]      nt_idx, nt_midx;
    logic                  ram_we;
    logic [NT_AW-1:0]      ram_addr;
    logic [7:0]            ram_wdata, ram_rdata;
    logic                  out_load;
    logic [7:0]            rd_item;
    logic [1:0]            op_item;
    logic [12:0]           caddr_item;
    logic [7:0]            cdata_item;

    // Decode
    always_comb begin
        is_pal   = (s_addr >= PAL_BASE);
        is_nt    = !is_pal && (s_addr >= NT_BASE);
        is_write = (s_func == FUNC_WRITE);
        pal_idx  = s_addr[PAL_AW-1:0];
        nt_raw   = s_addr[NT_FIELD_W-1:0];
        nt_mraw  = (mirror_mode_reg == MIRROR_HORZ) ? (nt_raw ^ NT_MIRROR_H)
                                                    : (nt_raw ^ NT_MIRROR_V);
        // Index wraps modulo the nametable depth (raw index < 2 * depth).
        nt_full  = {1'b0, nt_raw};
        nt_mfull = {1'b0, nt_mraw};
        if (nt_full >= NT_DEPTH_W) begin
            nt_full = nt_full - NT_DEPTH_W;
        end
        if (nt_mfull >= NT_DEPTH_W) begin
            nt_mfull = nt_mfull - NT_DEPTH_W;
        end
        nt_idx  = nt_full[NT_AW-1:0];
        nt_midx = nt_mfull[NT_AW-1:0];
    end

    assign st.is_nt       = is_nt;
    assign st.is_write    = is_write;
    assign st.need_mirror = is_nt && is_write &&
                            (mirror_mode_reg == MIRROR_HORZ ||
                             mirror_mode_reg == MIRROR_VERT);
    assign st.clear_last  = (clr_cnt_reg == NT_LAST);
    assign st.out_valid   = out_valid_reg;

    // Nametable RAM port
    always_comb begin
        ram_we    = cmd.clear_step || cmd.wr_mirror ||
                    (cmd.load_item && is_nt && is_write);
        ram_addr  = nt_idx;
        ram_wdata = s_wdata;
        if (cmd.clear_step) begin
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.wr_mirror) begin
            ram_addr  = mir_idx_reg;
            ram_wdata = mir_data_reg;
        end
    end

    pvmm_ram #(
        .WIDTH (8),
        .DEPTH (NAMETABLE_DEPTH)
    ) u_nt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Result of an item that completes at accept
    always_comb begin
        rd_item    = '0;
        op_item    = CART_NONE;
        caddr_item = '0;
        cdata_item = '0;
        if (is_pal) begin
            if (!is_write) begin
                rd_item = pal_reg[pal_idx];
            end
        end else if (!is_nt) begin
            if (is_write) begin
                if (cart_ram_reg) begin
                    op_item    = CART_WR_RAM;
                    caddr_item = s_addr[12:0];
                    cdata_item = s_wdata;
                end
            end else begin
                op_item    = cart_ram_reg ? CART_RD_RAM : CART_RD_VROM;
                caddr_item = s_addr[12:0];
            end
        end
    end

    always_comb begin
        mirror_mode_next = mirror_mode_reg;
        cart_ram_next    = cart_ram_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIRROR_MODE:  mirror_mode_next = cfg_wdata;
                CFG_CART_HAS_RAM: cart_ram_next    = cfg_wdata[0];
            endcase
        end

        pal_next = pal_reg;
        if (cmd.load_item && is_pal && is_write) begin
            pal_next[pal_idx] = s_wdata;
            if (pal_idx[1:0] == 2'b00) begin
                pal_next[pal_idx ^ PAL_MIRROR] = s_wdata;
            end
        end

        clr_cnt_next = cmd.clear_step ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

        mir_idx_next  = mir_idx_reg;
        mir_data_next = mir_data_reg;
        if (cmd.load_item) begin
            mir_idx_next  = nt_midx;
            mir_data_next = s_wdata;
        end

        out_load = (cmd.load_item && !(is_nt && !is_write)) || cmd.cap_read;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_ready);
        rd_next    = rd_reg;
        op_next    = op_reg;
        caddr_next = caddr_reg;
        cdata_next = cdata_reg;
        if (cmd.cap_read) begin
            rd_next    = ram_rdata;
            op_next    = CART_NONE;
            caddr_next = '0;
            cdata_next = '0;
        end else if (out_load) begin
            rd_next    = rd_item;
            op_next    = op_item;
            caddr_next = caddr_item;
            cdata_next = cdata_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_mode_reg <= MIRROR_NONE;
            cart_ram_reg    <= 1'b0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < PAL_DEPTH; i++) begin
                pal_reg[i] <= '0;
            end
        end else begin
            mirror_mode_reg <= mirror_mode_next;
            cart_ram_reg    <= cart_ram_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            pal_reg         <= pal_next;
        end
    end

    always_ff @(posedge aclk) begin
        mir_idx_reg  <= mir_idx_next;
        mir_data_reg <= mir_data_next;
        rd_reg       <= rd_next;
        op_reg       <= op_next;
        caddr_reg    <= caddr_next;
        cdata_reg    <= cdata_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = rd_reg;
    assign m_cart_op   = op_reg;
    assign m_cart_addr = caddr_reg;
    assign m_cart_data = cdata_reg;

    // At most one source drives the RAM port in a cycle
    `PVMM_ASSERT(a_ram_one_source, aclk, aresetn,
        $onehot0({cmd.clear_step, cmd.wr_mirror, cmd.load_item}))
    // A loaded result never overwrites one that is still waiting
    `PVMM_ASSERT(a_no_overwrite, aclk, aresetn,
        out_load |-> (!out_valid_reg || m_ready))

endmodule

>>> rtl/core/pvmm_ctrl.sv
// ----------------------------------------------------------------------------
// pvmm_ctrl
// Controller: clearing pass, accept, mirrored write and nametable read steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvmm_ctrl
    import pvmm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_MIRROR = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE) && (!st.out_valid || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.load_item  = accept;
        cmd.wr_mirror  = (state_reg == ST_MIRROR);
        cmd.cap_read   = (state_reg == ST_READ);
        cmd.clear_step = (state_reg == ST_CLEAR);
        state_next     = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && st.is_nt) begin
                    if (!st.is_write) begin
                        state_next = ST_READ;
                    end else if (st.need_mirror) begin
                        state_next = ST_MIRROR;
                    end
                end
            end
            ST_MIRROR: state_next = ST_IDLE;
            ST_READ:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Nametable read data lands in the result register in the cycle after the read state
    `PVMM_ASSERT(a_read_completes, aclk, aresetn,
        (state_reg == ST_READ) |=> st.out_valid)
    // The clearing pass runs to its last entry without interruption
    `PVMM_ASSERT(a_clear_holds, aclk, aresetn,
        (state_reg == ST_CLEAR && !st.clear_last) |=> (state_reg == ST_CLEAR))
    // No transaction is taken during the clearing pass
    `PVMM_ASSERT_ALWAYS(a_no_accept_clear, aclk,
        (state_reg == ST_CLEAR) |-> !accept)

endmodule
